@@ src/ghfna_pkg.sv @@
package ghfna_pkg;

  localparam int VALUE_W = 32;
  localparam int ERROR_W = 32;
  localparam int CELL_W  = VALUE_W + ERROR_W;
  localparam int CFG_W   = 6;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD0  = 10'b00_0000_0010,
    S_RD1  = 10'b00_0000_0100,
    S_RD2  = 10'b00_0000_1000,
    S_NB   = 10'b00_0001_0000,
    S_SQ   = 10'b00_0010_0000,
    S_SQRT = 10'b00_0100_0000,
    S_DIV  = 10'b00_1000_0000,
    S_WR   = 10'b01_0000_0000,
    S_PWR  = 10'b10_0000_0000
  } state_t;

  // which cells the sequencer is working through
  typedef enum logic [1:0] {
    PH_STREAM    = 2'd0,
    PH_FLUSH_OLD = 2'd1,
    PH_FLUSH_NEW = 2'd2
  } phase_t;

  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 34;

endpackage

@@ src/ghfna_in_if.sv @@
interface ghfna_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ghfna_pkg::VALUE_W-1:0] cell_value;
  logic        [ghfna_pkg::ERROR_W-1:0] cell_error;
  logic                                cell_missing;
  logic                                last_cell;

  modport source (output valid, cell_value, cell_error, cell_missing, last_cell, input ready);
  modport sink   (input valid, cell_value, cell_error, cell_missing, last_cell, output ready);
endinterface

@@ src/ghfna_out_if.sv @@
interface ghfna_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ghfna_pkg::VALUE_W-1:0] out_value;
  logic        [ghfna_pkg::ERROR_W-1:0] out_error;
  logic                                out_filled;
  logic                                out_last;

  modport source (output valid, out_value, out_error, out_filled, out_last, input ready);
  modport sink   (input valid, out_value, out_error, out_filled, out_last, output ready);
endinterface

@@ src/grid_hole_fill_neighbor_average_core.sv @@
// grid hole filling by four-neighbor averaging
// in_ch takes grid cells in column-major order, rows_in_use cells per column;
// out_ch returns the corrected cells one column behind, and the cell marked
// last_cell flushes every cell still held, the final one with out_last set.
// cfg_we/cfg_wdata write rows_in_use; the user must do so only while the block
// is idle, the block itself does not enforce it. each transaction on in_ch runs
// a sequencer around one 32x32 multiplier, a 2-bit-per-step square root and a
// 1-bit-per-step divide by the neighbor count. a cell that needs no fill goes
// from the ram reads to write-back; a filled cell runs 5 square/accumulate,
// 33 root and 34 divide steps in between. each input also passes accept and
// column store, and a last cell repeats the reads to write-back per flushed cell.
// in_ch.ready is high only while the sequencer is idle.
// results sit in an output register; while out_ch stalls the sequencer
// waits at write-back and no further input is taken.
// reset (rst_n low, synchronous) clears the row position, the column count
// and the output valid, and sets rows_in_use to 32. the column memories are
// not cleared; the first columns only read entries already written.
module grid_hole_fill_neighbor_average_core #(
  parameter int MAX_ROWS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ghfna_in_if.sink                      in_ch,
  ghfna_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [ghfna_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = ghfna_pkg::CELL_W;
  localparam int VW = ghfna_pkg::VALUE_W;

  ghfna_pkg::state_t state_r, state_nxt;
  ghfna_pkg::phase_t phase_r, phase_nxt;

  logic [ghfna_pkg::CFG_W-1:0] rows_r;
  logic [RW-1:0] row_pos_r, row_pos_nxt;
  logic [1:0]    ccnt_r, ccnt_nxt;

  logic [VW-1:0] inc_val_r, inc_val_nxt;
  logic [VW-1:0] inc_err_r, inc_err_nxt;
  logic          last_r, last_nxt;
  logic [RW-1:0] p_r, p_nxt, r_r, r_nxt;
  logic [RW-1:0] q_r, q_nxt, top_r, top_nxt;
  logic          has_left_r, has_left_nxt, has_right_r, has_right_nxt;
  logic          is_last_r, is_last_nxt;

  logic [CW-1:0] cell_r, cell_nxt, left_r, left_nxt, above_r, above_nxt;
  logic [CW-1:0] below_r, below_nxt;
  logic [3:0]    use_r, use_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic signed [33:0] sum_r, sum_nxt;
  logic [65:0]   acc_r, acc_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [2:0]    j_r, j_nxt;
  logic [36:0]   rem_r, rem_nxt;
  logic [32:0]   root_r, root_nxt;
  logic [5:0]    it_r, it_nxt;
  logic [33:0]   qa_r, qa_nxt, qb_r, qb_nxt;
  logic [2:0]    ra_r, ra_nxt, rb_r, rb_nxt;
  logic          neg_r, neg_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_val_r, out_val_nxt, out_err_r, out_err_nxt;
  logic          out_filled_r, out_filled_nxt, out_last_r, out_last_nxt;
  logic [VW-1:0] res_val_r, res_val_nxt, res_err_r, res_err_nxt;
  logic          res_filled_r, res_filled_nxt;

  logic [CW-1:0] pend_rdata, fin_rdata;
  logic [AW-1:0] pend_raddr, fin_raddr;
  logic          pend_we, fin_we;

  logic [RW-1:0] eff_rows;
  logic [6:0]    rows_ext;
  logic [RW-1:0] q_inc, p_inc;
  logic          fire_wr;

  logic [CW-1:0] nbv [4];
  logic [3:0]    ok, usable;
  logic [2:0]    n_cnt;
  logic signed [33:0] nb_sum;
  logic [31:0]   sq_e;
  logic [36:0]   rem_sh, trial;
  logic [3:0]    ta, tb;
  logic [33:0]   qa_step, qb_step, mag;
  logic [2:0]    ra_step, rb_step;
  logic [32:0]   root_step;
  logic [33:0]   avg;

  always_comb begin
    rows_ext = {1'b0, rows_r};
    if (rows_r == '0) begin
      eff_rows = RW'(1);
    end else if (rows_ext > 7'(MAX_ROWS)) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = rows_r[RW-1:0];
    end
  end

  assign q_inc = q_r + RW'(1);
  assign p_inc = p_r + RW'(1);

  assign in_ch.ready = (state_r == ghfna_pkg::S_IDLE);
  assign fire_wr     = (state_r == ghfna_pkg::S_WR) && (!out_valid_r || out_ch.ready);

  // neighbors: above, below (this column filled), left (filled), right (received)
  assign nbv[0] = above_r;
  assign nbv[1] = below_r;
  assign nbv[2] = left_r;
  assign nbv[3] = {inc_err_r, inc_val_r};
  assign ok     = {has_right_r, has_left_r, (q_r != '0), (q_r < top_r)};

  always_comb begin
    n_cnt  = '0;
    nb_sum = '0;
    for (int k = 0; k < 4; k++) begin
      usable[k] = ok[k] && (nbv[k][VW-1:0] != '0);
      if (usable[k]) begin
        n_cnt  = n_cnt + 3'd1;
        nb_sum = nb_sum + 34'(signed'(nbv[k][VW-1:0]));
      end
    end
  end

  assign sq_e = (j_r < 3'd4 && use_r[j_r[1:0]]) ? nbv[j_r[1:0]][CW-1:VW] : '0;

  // digit-by-digit root, two radicand bits per step
  assign rem_sh    = {rem_r[34:0], acc_r[65:64]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign root_step = {root_r[31:0], (rem_sh >= trial)};

  // restoring division of both lanes by the neighbor count
  assign ta      = {ra_r, qa_r[33]};
  assign tb      = {rb_r, qb_r[33]};
  assign ra_step = (ta >= {1'b0, cnt_r}) ? 3'(ta - {1'b0, cnt_r}) : ta[2:0];
  assign rb_step = (tb >= {1'b0, cnt_r}) ? 3'(tb - {1'b0, cnt_r}) : tb[2:0];
  assign qa_step = {qa_r[32:0], (ta >= {1'b0, cnt_r})};
  assign qb_step = {qb_r[32:0], (tb >= {1'b0, cnt_r})};
  assign mag     = sum_r[33] ? 34'(-sum_r) : 34'(sum_r);
  assign avg     = neg_r ? 34'(-qa_step) : qa_step;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    row_pos_nxt   = row_pos_r;
    ccnt_nxt      = ccnt_r;
    inc_val_nxt   = inc_val_r;
    inc_err_nxt   = inc_err_r;
    last_nxt      = last_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    top_nxt       = top_r;
    has_left_nxt  = has_left_r;
    has_right_nxt = has_right_r;
    is_last_nxt   = is_last_r;
    cell_nxt      = cell_r;
    left_nxt      = left_r;
    above_nxt     = above_r;
    below_nxt     = below_r;
    use_nxt       = use_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    it_nxt        = it_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    neg_nxt       = neg_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    res_filled_nxt = res_filled_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    out_filled_nxt = out_filled_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    pend_raddr    = q_inc[AW-1:0];
    fin_raddr     = AW'(q_r - RW'(1));
    pend_we       = 1'b0;
    fin_we        = 1'b0;

    unique case (state_r)
      ghfna_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          inc_val_nxt = in_ch.cell_missing ? '0 : in_ch.cell_value;
          inc_err_nxt = in_ch.cell_error;
          last_nxt    = in_ch.last_cell;
          r_nxt       = eff_rows;
          p_nxt       = row_pos_r;
          ccnt_nxt    = ccnt_r;
          // a shrunk row count starts a new column
          if (row_pos_r >= eff_rows) begin
            p_nxt = '0;
            if (ccnt_r < 2'd2) ccnt_nxt = ccnt_r + 2'd1;
          end
          phase_nxt     = ghfna_pkg::PH_STREAM;
          q_nxt         = p_nxt;
          top_nxt       = eff_rows - RW'(1);
          has_left_nxt  = (ccnt_nxt >= 2'd2);
          has_right_nxt = 1'b1;
          is_last_nxt   = 1'b0;
          state_nxt     = (ccnt_nxt >= 2'd1) ? ghfna_pkg::S_RD0 : ghfna_pkg::S_PWR;
        end
      end
      ghfna_pkg::S_RD0: begin
        pend_raddr = q_r[AW-1:0];
        fin_raddr  = q_r[AW-1:0];
        state_nxt  = ghfna_pkg::S_RD1;
      end
      ghfna_pkg::S_RD1: begin
        cell_nxt  = pend_rdata;
        left_nxt  = fin_rdata;
        state_nxt = ghfna_pkg::S_RD2;
      end
      ghfna_pkg::S_RD2: begin
        above_nxt = pend_rdata;
        below_nxt = fin_rdata;
        state_nxt = ghfna_pkg::S_NB;
      end
      ghfna_pkg::S_NB: begin
        if (cell_r[VW-1:0] != '0 || n_cnt == '0) begin
          res_val_nxt    = cell_r[VW-1:0];
          res_err_nxt    = cell_r[CW-1:VW];
          res_filled_nxt = 1'b0;
          state_nxt      = ghfna_pkg::S_WR;
        end else begin
          use_nxt   = usable;
          cnt_nxt   = n_cnt;
          sum_nxt   = nb_sum;
          acc_nxt   = '0;
          prod_nxt  = '0;
          j_nxt     = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = ghfna_pkg::S_SQ;
        end
      end
      ghfna_pkg::S_SQ: begin
        prod_nxt = sq_e * sq_e;
        acc_nxt  = acc_r + {2'b00, prod_r};
        j_nxt    = j_r + 3'd1;
        if (j_r == 3'd4) begin
          it_nxt    = '0;
          state_nxt = ghfna_pkg::S_SQRT;
        end
      end
      ghfna_pkg::S_SQRT: begin
        rem_nxt  = (rem_sh >= trial) ? (rem_sh - trial) : rem_sh;
        root_nxt = root_step;
        acc_nxt  = {acc_r[63:0], 2'b00};
        it_nxt   = it_r + 6'd1;
        if (it_r == 6'(ghfna_pkg::SQRT_STEPS - 1)) begin
          it_nxt    = '0;
          qa_nxt    = mag;
          neg_nxt   = sum_r[33];
          qb_nxt    = {1'b0, root_step};
          ra_nxt    = '0;
          rb_nxt    = '0;
          state_nxt = ghfna_pkg::S_DIV;
        end
      end
      ghfna_pkg::S_DIV: begin
        qa_nxt = qa_step;
        qb_nxt = qb_step;
        ra_nxt = ra_step;
        rb_nxt = rb_step;
        it_nxt = it_r + 6'd1;
        if (it_r == 6'(ghfna_pkg::DIV_STEPS - 1)) begin
          res_val_nxt    = avg[VW-1:0];
          res_err_nxt    = (qb_step[33:32] != '0) ? '1 : qb_step[31:0];
          res_filled_nxt = 1'b1;
          state_nxt      = ghfna_pkg::S_WR;
        end
      end
      ghfna_pkg::S_WR: begin
        if (fire_wr) begin
          fin_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_val_nxt    = res_val_r;
          out_err_nxt    = res_err_r;
          out_filled_nxt = res_filled_r;
          out_last_nxt   = is_last_r;
          case (phase_r)
            ghfna_pkg::PH_STREAM: begin
              state_nxt = ghfna_pkg::S_PWR;
            end
            ghfna_pkg::PH_FLUSH_OLD: begin
              state_nxt = ghfna_pkg::S_RD0;
              if (q_inc < r_r) begin
                q_nxt = q_inc;
              end else begin
                phase_nxt    = ghfna_pkg::PH_FLUSH_NEW;
                q_nxt        = '0;
                top_nxt      = p_r;
                has_left_nxt = (ccnt_r >= 2'd1);
                is_last_nxt  = (p_r == '0);
              end
            end
            default: begin
              if (q_r == p_r) begin
                row_pos_nxt = '0;
                ccnt_nxt    = '0;
                state_nxt   = ghfna_pkg::S_IDLE;
              end else begin
                q_nxt       = q_inc;
                is_last_nxt = (q_inc == p_r);
                state_nxt   = ghfna_pkg::S_RD0;
              end
            end
          endcase
        end
      end
      ghfna_pkg::S_PWR: begin
        pend_we       = 1'b1;
        has_right_nxt = 1'b0;
        if (last_r) begin
          state_nxt = ghfna_pkg::S_RD0;
          if (ccnt_r >= 2'd1 && p_inc < r_r) begin
            phase_nxt    = ghfna_pkg::PH_FLUSH_OLD;
            q_nxt        = p_inc;
            top_nxt      = r_r - RW'(1);
            has_left_nxt = (ccnt_r >= 2'd2);
            is_last_nxt  = 1'b0;
          end else begin
            phase_nxt    = ghfna_pkg::PH_FLUSH_NEW;
            q_nxt        = '0;
            top_nxt      = p_r;
            has_left_nxt = (ccnt_r >= 2'd1);
            is_last_nxt  = (p_r == '0);
          end
        end else begin
          state_nxt = ghfna_pkg::S_IDLE;
          if (p_inc >= r_r) begin
            row_pos_nxt = '0;
            if (ccnt_r < 2'd2) ccnt_nxt = ccnt_r + 2'd1;
          end else begin
            row_pos_nxt = p_inc;
          end
        end
      end
      default: begin
        state_nxt = ghfna_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghfna_pkg::S_IDLE;
      phase_r     <= ghfna_pkg::PH_STREAM;
      rows_r      <= ghfna_pkg::CFG_W'(32);
      row_pos_r   <= '0;
      ccnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      row_pos_r   <= row_pos_nxt;
      ccnt_r      <= ccnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rows_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_val_r    <= inc_val_nxt;
    inc_err_r    <= inc_err_nxt;
    last_r       <= last_nxt;
    p_r          <= p_nxt;
    r_r          <= r_nxt;
    q_r          <= q_nxt;
    top_r        <= top_nxt;
    has_left_r   <= has_left_nxt;
    has_right_r  <= has_right_nxt;
    is_last_r    <= is_last_nxt;
    cell_r       <= cell_nxt;
    left_r       <= left_nxt;
    above_r      <= above_nxt;
    below_r      <= below_nxt;
    use_r        <= use_nxt;
    cnt_r        <= cnt_nxt;
    sum_r        <= sum_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    j_r          <= j_nxt;
    rem_r        <= rem_nxt;
    root_r       <= root_nxt;
    it_r         <= it_nxt;
    qa_r         <= qa_nxt;
    qb_r         <= qb_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    neg_r        <= neg_nxt;
    res_val_r    <= res_val_nxt;
    res_err_r    <= res_err_nxt;
    res_filled_r <= res_filled_nxt;
    out_val_r    <= out_val_nxt;
    out_err_r    <= out_err_nxt;
    out_filled_r <= out_filled_nxt;
    out_last_r   <= out_last_nxt;
  end

  ghfna_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (p_r[AW-1:0]),
    .wdata ({inc_err_r, inc_val_r}),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  ghfna_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (q_r[AW-1:0]),
    .wdata ({res_err_r, res_val_r}),
    .raddr (fin_raddr),
    .rdata (fin_rdata)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_value  = out_val_r;
  assign out_ch.out_error  = out_err_r;
  assign out_ch.out_filled = out_filled_r;
  assign out_ch.out_last   = out_last_r;

`ifndef SYNTHESIS
  a_row_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_pos_r < RW'(MAX_ROWS))
    else $error("row position beyond column depth");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ghfna_pkg::S_DIV || state_r == ghfna_pkg::S_SQRT) |-> cnt_r != '0)
    else $error("average started with no usable neighbor");

  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ghfna_pkg::PH_FLUSH_NEW && state_r != ghfna_pkg::S_IDLE) |-> q_r <= p_r)
    else $error("flush ran past the last cell");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_wr && is_last_r) |=> state_r == ghfna_pkg::S_IDLE && ccnt_r == '0)
    else $error("last result did not end the grid");
`endif

endmodule

@@ src/ghfna_ram.sv @@
module ghfna_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [ghfna_pkg::VALUE_W-1:0] value;
    logic [ghfna_pkg::ERROR_W-1:0]        error;
    logic                                 filled;
    logic                                 last;
  } cell_result_t;

  // tracks the grid state and holds the corrected cells still to come out
  class hole_fill_scoreboard;
    logic [ghfna_pkg::CELL_W-1:0] pending_col [MAX_ROWS];
    logic [ghfna_pkg::CELL_W-1:0] finished_col [MAX_ROWS];
    int unsigned row_pos;
    int unsigned col_count;
    int unsigned rows_cfg;
    cell_result_t awaited [$];
    int errors;

    function new();
      row_pos = 0;
      col_count = 0;
      rows_cfg = 32;
      errors = 0;
      foreach (pending_col[i]) pending_col[i] = '0;
      foreach (finished_col[i]) finished_col[i] = '0;
    endfunction

    function void set_rows(logic [ghfna_pkg::CFG_W-1:0] v);
      rows_cfg = v;
    endfunction

    function logic [32:0] floor_root(logic [65:0] acc);
      logic [32:0] r;
      logic [32:0] c;
      logic [67:0] cc;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (33'd1 << b);
        cc = {35'd0, c} * {35'd0, c};
        if (cc <= {2'b00, acc}) r = c;
      end
      return r;
    endfunction

    function void fill_cell(int unsigned q, int unsigned top, bit has_left, bit has_right,
                            logic [ghfna_pkg::CELL_W-1:0] right, bit is_last);
      logic [ghfna_pkg::CELL_W-1:0] c;
      logic [ghfna_pkg::CELL_W-1:0] nb [4];
      bit ok [4];
      logic [ghfna_pkg::CELL_W-1:0] res;
      longint sum;
      logic [65:0] acc;
      logic [63:0] e;
      logic [32:0] err;
      int n;
      cell_result_t r;
      c = pending_col[q];
      res = c;
      sum = 0;
      acc = '0;
      n = 0;
      r.filled = 1'b0;
      ok[0] = q < top;     nb[0] = ok[0] ? pending_col[q + 1] : '0;
      ok[1] = q > 0;       nb[1] = ok[1] ? finished_col[q - 1] : '0;
      ok[2] = has_left;    nb[2] = finished_col[q];
      ok[3] = has_right;   nb[3] = right;
      if (c[ghfna_pkg::VALUE_W-1:0] == '0) begin
        for (int i = 0; i < 4; i++) begin
          if (ok[i] && nb[i][ghfna_pkg::VALUE_W-1:0] != '0) begin
            e = {32'd0, nb[i][ghfna_pkg::CELL_W-1:ghfna_pkg::VALUE_W]};
            sum += longint'($signed(nb[i][ghfna_pkg::VALUE_W-1:0]));
            acc += {2'b00, e * e};
            n++;
          end
        end
        if (n > 0) begin
          sum = sum / longint'(n);
          err = floor_root(acc) / n;
          if (err[32]) err = 33'h0_FFFF_FFFF;
          res = {err[31:0], sum[31:0]};
          r.filled = 1'b1;
        end
      end
      finished_col[q] = res;
      r.value = res[ghfna_pkg::VALUE_W-1:0];
      r.error = res[ghfna_pkg::CELL_W-1:ghfna_pkg::VALUE_W];
      r.last = is_last;
      awaited.push_back(r);
    endfunction

    function void note_input(logic [31:0] v, logic [31:0] e, bit missing, bit last);
      int unsigned rows;
      int unsigned p;
      logic [ghfna_pkg::CELL_W-1:0] incoming;
      rows = rows_cfg == 0 ? 1 : (rows_cfg > MAX_ROWS ? MAX_ROWS : rows_cfg);
      p = row_pos;
      incoming = {e, missing ? 32'd0 : v};
      if (p >= rows) begin
        p = 0;
        if (col_count < 2) col_count++;
      end
      if (col_count >= 1) fill_cell(p, rows - 1, col_count >= 2, 1, incoming, 0);
      pending_col[p] = incoming;
      if (last) begin
        if (col_count >= 1)
          for (int unsigned q = p + 1; q < rows; q++)
            fill_cell(q, rows - 1, col_count >= 2, 0, '0, 0);
        for (int unsigned q = 0; q <= p; q++)
          fill_cell(q, p, col_count >= 1, 0, '0, q == p);
        row_pos = 0;
        col_count = 0;
      end else if (p + 1 >= rows) begin
        row_pos = 0;
        if (col_count < 2) col_count++;
      end else begin
        row_pos = p + 1;
      end
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result value=%h error=%h filled=%b last=%b",
                 $time, got.value, got.error, got.filled, got.last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value expected %h actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.error !== want.error) begin
        $display("%0t: error expected %h actual %h", $time, want.error, got.error);
        errors++;
      end
      if (got.filled !== want.filled) begin
        $display("%0t: filled expected %b actual %b", $time, want.filled, got.filled);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ghfna_pkg::CFG_W-1:0] cfg_wdata;

  ghfna_in_if  in_ch();
  ghfna_out_if out_ch();

  grid_hole_fill_neighbor_average_core #(.MAX_ROWS(MAX_ROWS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hole_fill_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int sent_cells;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: check, then pick next ready; watchdog on stalled traffic
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.out_value, out_ch.out_error, out_ch.out_filled,
                         out_ch.out_last});
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_rows(logic [ghfna_pkg::CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_rows(v);
  endtask

  task automatic send_cell(logic [31:0] v, logic [31:0] e, bit missing, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cell_value <= v;
    in_ch.cell_error <= e;
    in_ch.cell_missing <= missing;
    in_ch.last_cell <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(v, e, missing, last);
    sent_cells++;
    if (last) in_ch.valid <= 1'b0;
  endtask

  // let every result of the grid come out before touching the register
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_grid(int unsigned n);
    logic [31:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      v = ($urandom_range(99) < 45) ? 32'd0 : pick_word();
      send_cell(v, pick_word(), $urandom_range(99) < 15, i == n - 1);
    end
  endtask

  initial begin
    int unsigned sel;
    int unsigned rows;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cell_value = '0;
    in_ch.cell_error = '0;
    in_ch.cell_missing = 1'b0;
    in_ch.last_cell = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_cells = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default 32 rows, grid ends early inside the first column
    send_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'h0, 32'h0001_0000, 0, 0);
    send_cell(32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'h1234_5678, 32'h0, 1, 1);
    drain();

    // three rows, last cell closes the full third column
    write_rows(6'd3);
    send_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'h0, 32'h0, 0, 0);
    send_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    send_cell(32'h0, 32'h5555_AAAA, 0, 0);
    send_cell(32'h8000_0000, 32'h0000_0001, 0, 0);
    send_cell(32'h0, 32'h0, 0, 0);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'h0, 32'h0, 0, 1);
    drain();

    // zero acts as one row, every cell but the third is a hole
    write_rows(6'd0);
    send_cell(32'h0, 32'hFFFF_FFFF, 1, 0);
    send_cell(32'h0, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_cell(32'h0, 32'h0, 0, 1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      while (sent_cells < 20 + 70 * (ph + 1)) begin
        send_idle_pct = ph == 0 ? 14 : (ph == 1 ? 79 : 0);
        recv_idle_pct = ph == 0 ? 79 : (ph == 1 ? 14 : 0);
        sel = $urandom_range(9);
        rows = sel == 0 ? 0 : (sel == 1 ? 63 : (sel == 2 ? 32 : $urandom_range(1, 6)));
        write_rows(rows[ghfna_pkg::CFG_W-1:0]);
        if (rows >= 32) random_grid($urandom_range(1, 40));
        else random_grid($urandom_range(1, (rows + 1) * 4));
        drain();
      end
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
